// File: design/ascii_number_parser_core_assert.svh
// Assertion macros shared by the parser's checker module.
`ifndef ASCII_NUMBER_PARSER_CORE_ASSERT_SVH
`define ASCII_NUMBER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and idle in reset.
`define ANP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed in the same cycle");

// Next-cycle implication, sampled on the rising clock and idle in reset.
`define ANP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed one cycle later");

`endif

// File: design/anp_pkg.sv
// Types, codes and helper functions of the ASCII number parser.
`default_nettype none

package anp_pkg;

  // Parse phase of the state machine.
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_ZERO  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  // Number base in force.
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_MISSING = 2'd2,
    ST_BADDIG  = 2'd3
  } status_t;

  localparam int unsigned CharW = 8;
  localparam int unsigned NumW  = 32;

  // Character codes.
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_UC_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UC_F  = 8'h46;
  localparam logic [CharW-1:0] CH_UC_X  = 8'h58;
  localparam logic [CharW-1:0] CH_LC_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LC_F  = 8'h66;
  localparam logic [CharW-1:0] CH_LC_X  = 8'h78;
  localparam logic [CharW-1:0] DigitTen = 8'd10;

  // Decoded hex-digit character.
  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } digit_t;

  // One result item as it travels between the parse logic and the output register.
  typedef struct packed {
    status_t         status;
    logic [NumW-1:0] number_value;
    logic            char_consumed;
    radix_t          radix_used;
  } result_t;

  // Decode a hex-digit character into its value.
  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    d.hit = 1'b1;
    d.val = 4'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d.val = 4'(c - CH_ZERO);
    end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
      d.val = 4'(c - CH_LC_A + DigitTen);
    end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
      d.val = 4'(c - CH_UC_A + DigitTen);
    end else begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

  // True when a digit value lies below the base.
  function automatic logic digit_fits(input radix_t r, input logic [3:0] v);
    logic ok;
    case (r)
      RX_HEX:  ok = 1'b1;
      RX_OCT:  ok = (v < 4'd8);
      default: ok = (v < 4'd10);
    endcase
    return ok;
  endfunction

  // Accumulate one digit: n * base + d, wrapping at the word width, built from shifts.
  function automatic logic [NumW-1:0] mac(input radix_t r, input logic [NumW-1:0] n,
                                          input logic [3:0] v);
    logic [NumW-1:0] scaled;
    case (r)
      RX_HEX:  scaled = n << 4;
      RX_OCT:  scaled = n << 3;
      default: scaled = (n << 3) + (n << 1);
    endcase
    return scaled + NumW'(v);
  endfunction

endpackage

`default_nettype wire

// File: design/anp_in_stage.sv
// Input register of the parser: captures one character item and holds it until it advances.
`default_nettype none

module anp_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [anp_pkg::CharW-1:0]   in_character,
  input  wire logic                        advance,
  output logic                             held_valid,
  output logic [anp_pkg::CharW-1:0]        held_char
);

  logic                       valid_r, valid_nxt;
  logic [anp_pkg::CharW-1:0]  char_r;
  logic                       take;

  // The register is full only while its item cannot move on.
  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      char_r <= in_character;
    end
  end

  assign held_valid = valid_r;
  assign held_char  = char_r;

endmodule

`default_nettype wire

// File: design/anp_step.sv
// Parse logic and parser state: turns one character into one result and the next state.
`default_nettype none

module anp_step (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic [anp_pkg::CharW-1:0] char_i,
  output anp_pkg::result_t               result_o
);

  anp_pkg::phase_t             phase_r, phase_nxt;
  anp_pkg::radix_t             radix_r, radix_nxt;
  logic [anp_pkg::NumW-1:0]    acc_r, acc_nxt;

  anp_pkg::digit_t   dig;
  anp_pkg::radix_t   radix_seen;
  anp_pkg::status_t  status;
  logic              is_blank, is_end, is_zero, is_x, digit_path, bad_digit;

  // Character classes.
  assign dig      = anp_pkg::digit_of(char_i);
  assign is_blank = (char_i == anp_pkg::CH_SPACE) || (char_i == anp_pkg::CH_TAB);
  assign is_end   = (char_i == anp_pkg::CH_NUL) || (char_i == anp_pkg::CH_LF);
  assign is_zero  = (char_i == anp_pkg::CH_ZERO);
  assign is_x     = (char_i == anp_pkg::CH_LC_X) || (char_i == anp_pkg::CH_UC_X);

  // Whether this character is treated as a digit candidate, and the base it meets.
  always_comb begin
    digit_path = 1'b0;
    radix_seen = radix_r;
    case (phase_r)
      anp_pkg::PH_LEAD: begin
        if (!is_blank && !is_end && !is_zero) begin
          digit_path = 1'b1;
          radix_seen = anp_pkg::RX_DEC;
        end
      end
      anp_pkg::PH_ZERO: begin
        if (is_x) begin
          radix_seen = anp_pkg::RX_HEX;
        end else begin
          digit_path = 1'b1;
          if (!is_end) begin
            radix_seen = anp_pkg::RX_OCT;
          end
        end
      end
      anp_pkg::PH_DIGIT: digit_path = 1'b1;
      default: ;
    endcase
  end

  assign bad_digit = dig.hit && !anp_pkg::digit_fits(radix_seen, dig.val);

  // Result of this character.
  always_comb begin
    status = anp_pkg::ST_BUSY;
    if (phase_r == anp_pkg::PH_LEAD && is_end) begin
      status = anp_pkg::ST_MISSING;
    end else if (digit_path) begin
      if (dig.hit) begin
        if (bad_digit) begin
          status = anp_pkg::ST_BADDIG;
        end
      end else if (!is_blank) begin
        status = anp_pkg::ST_DONE;
      end
    end else if (phase_r == anp_pkg::PH_TRAIL && !is_blank) begin
      status = anp_pkg::ST_DONE;
    end
    result_o.status        = status;
    result_o.number_value  = (status == anp_pkg::ST_DONE) ? acc_r : '0;
    result_o.char_consumed = (status == anp_pkg::ST_BUSY);
    result_o.radix_used    = radix_seen;
  end

  // Next state; any completion or error sends the parser back to idle.
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_seen;
    acc_nxt   = acc_r;
    if (status != anp_pkg::ST_BUSY) begin
      phase_nxt = anp_pkg::PH_LEAD;
      radix_nxt = anp_pkg::RX_DEC;
      acc_nxt   = '0;
    end else if (digit_path) begin
      if (dig.hit) begin
        phase_nxt = anp_pkg::PH_DIGIT;
        acc_nxt   = anp_pkg::mac(radix_seen, acc_r, dig.val);
      end else begin
        phase_nxt = anp_pkg::PH_TRAIL;
      end
    end else if (phase_r == anp_pkg::PH_LEAD && is_zero) begin
      phase_nxt = anp_pkg::PH_ZERO;
    end else if (phase_r == anp_pkg::PH_ZERO) begin
      phase_nxt = anp_pkg::PH_DIGIT;
    end
  end

  // State moves only when an item passes through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= anp_pkg::PH_LEAD;
      radix_r <= anp_pkg::RX_DEC;
      acc_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/anp_out_stage.sv
// Result register of the parser: holds one result item until the receiver takes it.
`default_nettype none

module anp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load_valid,
  input  wire anp_pkg::result_t load_result,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output anp_pkg::result_t      out_result
);

  logic              valid_r, valid_nxt;
  anp_pkg::result_t  result_r;

  // Room exists when empty or when the held item leaves this cycle.
  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = (load_valid && can_load) || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      result_r <= load_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// File: design/ascii_number_parser_core.sv
// ASCII number parser: takes one character item per clock cycle while in_stall is low and
// returns one result item for each. A character is registered on acceptance, parsed against
// the parser state and written to the result register once that register has room, so a new
// character can be accepted every cycle while the result register can take each result. The
// rate rests on the state update, whose multiply-add by 8, 10 or 16 is built from shifts and
// at most two adders. A held result does not block the input: the input register keeps taking
// items until both registers are full.
`default_nettype none

module ascii_number_parser_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [anp_pkg::CharW-1:0]   in_character,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [anp_pkg::NumW-1:0]         out_number_value,
  output logic                             out_char_consumed,
  output logic [1:0]                       out_radix_used
);

  logic                       held_valid;
  logic [anp_pkg::CharW-1:0]  held_char;
  logic                       can_load;
  logic                       advance;
  anp_pkg::result_t           step_result;
  anp_pkg::result_t           out_result;

  // An item advances when it is held and the result register has room.
  assign advance = held_valid && can_load;

  // Input register.
  anp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_char    (held_char)
  );

  // Parse logic and state.
  anp_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .char_i   (held_char),
    .result_o (step_result)
  );

  // Result register.
  anp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (held_valid),
    .load_result (step_result),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  // Result fields onto their ports.
  assign out_status        = out_result.status;
  assign out_number_value  = out_result.number_value;
  assign out_char_consumed = out_result.char_consumed;
  assign out_radix_used    = out_result.radix_used;

endmodule

`default_nettype wire

// File: design/anp_checker.sv
// Port-level checker for the ASCII number parser, bound to the top level.
`default_nettype none

`include "ascii_number_parser_core_assert.svh"

module anp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [anp_pkg::CharW-1:0]  in_character,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [1:0]                 out_status,
  input wire logic [anp_pkg::NumW-1:0]   out_number_value,
  input wire logic                       out_char_consumed,
  input wire logic [1:0]                 out_radix_used
);

  // A stalled input item stays offered with the same character.
  `ANP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_character))

  // A stalled result item stays in place with all its fields.
  `ANP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_number_value) && $stable(out_char_consumed) && $stable(out_radix_used))

  // A character is consumed exactly when the parse is still running.
  `ANP_ASSERT_NOW(a_consumed_busy, out_valid, out_char_consumed == (out_status == anp_pkg::ST_BUSY))

  // Only a completed number carries a value.
  `ANP_ASSERT_NOW(a_value_done, out_valid && out_status != anp_pkg::ST_DONE, out_number_value == '0)

  // A missing number is only ever seen before a base has been chosen.
  `ANP_ASSERT_NOW(a_missing_dec, out_valid && out_status == anp_pkg::ST_MISSING, out_radix_used == anp_pkg::RX_DEC)

endmodule

bind ascii_number_parser_core anp_checker u_anp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_character      (in_character),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_number_value  (out_number_value),
  .out_char_consumed (out_char_consumed),
  .out_radix_used    (out_radix_used)
);

`default_nettype wire
